>>> hw/rtl/qpd_pkg.sv
package qpd_pkg;

    // Default tree height, handed to the top level as a parameter default
    localparam int MAX_LEVELS_DEF = 6;

    // Preorder symbol codes
    localparam logic [1:0] SYM_INTERIOR = 2'd0;
    localparam logic [1:0] SYM_WHITE    = 2'd1;
    localparam logic [1:0] SYM_BLACK    = 2'd2;
    localparam logic [1:0] SYM_INVALID  = 2'd3;

    // Fill colour codes
    localparam logic [1:0] COL_NONE  = 2'd0;
    localparam logic [1:0] COL_WHITE = 2'd1;
    localparam logic [1:0] COL_BLACK = 2'd2;

    // Quadrant order below an interior node; the last one closes the level
    localparam logic [1:0] QUAD_ORIGIN = 2'd0;
    localparam logic [1:0] QUAD_ROW    = 2'd1;
    localparam logic [1:0] QUAD_BOTH   = 2'd2;
    localparam logic [1:0] QUAD_LAST   = 2'd3;

    // Register indexes
    localparam logic REG_LOG2_SIDE = 1'b0;

    localparam logic [2:0]  LOG2_SIDE_RST = 3'd6;
    localparam logic [12:0] BLACK_MAX     = 13'd8191;

    // One result word
    typedef struct packed {
        logic [5:0]  fill_row;
        logic [5:0]  fill_col;
        logic [6:0]  fill_side;
        logic [1:0]  fill_colour;
        logic [12:0] black_pixels;
        logic        image_done;
        logic        symbol_error;
    } t_result;

endpackage

>>> hw/rtl/qpd_step.sv
module qpd_step #(
    parameter int MAX_LEVELS = qpd_pkg::MAX_LEVELS_DEF,
    parameter int DW         = $clog2(MAX_LEVELS + 1)
) (
    input  logic [1:0]                  i_symbol,
    input  logic [2:0]                  i_levels,
    input  logic [MAX_LEVELS-1:0][1:0]  i_path,
    input  logic [DW-1:0]               i_depth,
    input  logic [12:0]                 i_black,
    input  logic                        i_complete,
    output logic [MAX_LEVELS-1:0][1:0]  o_path,
    output logic [DW-1:0]               o_depth,
    output logic [12:0]                 o_black,
    output logic                        o_complete,
    output qpd_pkg::t_result            o_res
);
    import qpd_pkg::*;

    localparam int CW = (DW > 3) ? DW : 3;

    logic [CW-1:0] w_d;
    logic [CW-1:0] w_lv;
    logic [2:0]    w_shift;
    logic [6:0]    w_row;
    logic [6:0]    w_col;
    logic [7:0]    w_side;
    logic [14:0]   w_area;
    logic [14:0]   w_sum;
    logic          w_found;
    logic [DW-1:0] w_next;

    assign w_d     = CW'(i_depth);
    assign w_lv    = CW'(i_levels);
    assign w_shift = 3'(w_lv - w_d);
    assign w_side  = 8'(1) << w_shift;
    assign w_area  = 15'(1) << {w_shift, 1'b0};
    assign w_sum   = {2'b00, i_black} + w_area;

    // Region origin from the quadrant path: each level decides one row bit and one column bit
    always_comb begin
        w_row = '0;
        w_col = '0;
        for (int k = 0; k < MAX_LEVELS; k++) begin
            if (k < int'(i_depth)) begin
                if (i_path[k] == QUAD_ROW || i_path[k] == QUAD_BOTH) begin
                    w_row = w_row | 7'(7'(1) << (int'(i_levels) - 1 - k));
                end
                if (i_path[k] == QUAD_BOTH || i_path[k] == QUAD_LAST) begin
                    w_col = w_col | 7'(7'(1) << (int'(i_levels) - 1 - k));
                end
            end
        end
    end

    // Deepest unfinished level on the path above the current node
    always_comb begin
        w_found = 1'b0;
        w_next  = '0;
        for (int j = 0; j < MAX_LEVELS; j++) begin
            if (j < int'(i_depth) && i_path[j] != QUAD_LAST) begin
                w_found = 1'b1;
                w_next  = DW'(j + 1);
            end
        end
    end

    // Next state and result word
    always_comb begin
        o_path     = i_path;
        o_depth    = i_depth;
        o_black    = i_black;
        o_complete = i_complete;
        o_res      = '0;
        if (i_complete || i_symbol == SYM_INVALID) begin
            o_res.symbol_error = 1'b1;
        end else if (i_symbol == SYM_INTERIOR) begin
            if (w_d >= w_lv) begin
                o_res.symbol_error = 1'b1;
            end else begin
                for (int k = 0; k < MAX_LEVELS; k++) begin
                    if (k == int'(i_depth)) begin
                        o_path[k] = QUAD_ORIGIN;
                    end
                end
                o_depth = DW'(i_depth + 1'b1);
            end
        end else begin
            o_res.fill_row    = w_row[5:0];
            o_res.fill_col    = w_col[5:0];
            o_res.fill_side   = w_side[6:0];
            o_res.fill_colour = (i_symbol == SYM_BLACK) ? COL_BLACK : COL_WHITE;
            if (i_symbol == SYM_BLACK) begin
                o_black = (w_sum > 15'(BLACK_MAX)) ? BLACK_MAX : w_sum[12:0];
            end
            // Pop finished levels and step to the next sibling
            if (!w_found) begin
                o_complete = 1'b1;
                o_depth    = '0;
            end else begin
                for (int k = 0; k < MAX_LEVELS; k++) begin
                    if (k + 1 == int'(w_next)) begin
                        o_path[k] = 2'(i_path[k] + 2'd1);
                    end
                end
                o_depth = w_next;
            end
        end
        o_res.black_pixels = o_black;
        o_res.image_done   = o_complete;
    end

endmodule

>>> hw/rtl/qpd_outbuf.sv
module qpd_outbuf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  qpd_pkg::t_result i_res,
    input  logic             i_ready,
    output logic             o_free,
    output logic             o_valid,
    output qpd_pkg::t_result o_res
);
    import qpd_pkg::*;

    logic    r_valid;
    t_result r_res;

    // Room for a new word when empty or when the held word leaves now
    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    // Hold the word until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

>>> hw/rtl/quadtree_preorder_image_decoder.sv
// Preorder quadtree decoder: turns a stream of tree symbols into square fill regions.
// Input channel: i_valid/o_ready with i_symbol (0 interior, 1 white, 2 black, 3 invalid).
// Output channel: o_valid/i_ready with one result word for every symbol accepted:
// region row, column, side and colour, running black pixel count, a done flag
// and an error flag for rejected symbols.
// The result word is registered and appears in the cycle after its symbol is accepted.
// Throughput: one symbol per cycle unless stalled; the path update is a single
// priority encode over the quadrant path register, between state and output register.
// When the receiver stalls, the output register holds its word and o_ready drops
// only while that word is still waiting and not taken in the same cycle.
// Reset clears the path, depth, black total and done flag and sets log2_side to 6.
// Writing log2_side over the APB port restarts the decode the same way; write it
// only while no word is in flight. Side values above MAX_LEVELS act as MAX_LEVELS.
module quadtree_preorder_image_decoder #(
    parameter int MAX_LEVELS = qpd_pkg::MAX_LEVELS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_symbol,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [5:0]  o_fill_row,
    output logic [5:0]  o_fill_col,
    output logic [6:0]  o_fill_side,
    output logic [1:0]  o_fill_colour,
    output logic [12:0] o_black_pixels,
    output logic        o_image_done,
    output logic        o_symbol_error,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import qpd_pkg::*;

    localparam int DW = $clog2(MAX_LEVELS + 1);

    logic [MAX_LEVELS-1:0][1:0] r_path;
    logic [MAX_LEVELS-1:0][1:0] n_path;
    logic [DW-1:0]              r_depth;
    logic [DW-1:0]              n_depth;
    logic [12:0]                r_black;
    logic [12:0]                n_black;
    logic                       r_complete;
    logic                       n_complete;
    logic [2:0]                 r_log2_side;
    logic [2:0]                 w_levels;
    logic                       w_accept;
    logic                       w_cfg_wr;
    logic                       w_free;
    t_result                    w_res;
    t_result                    w_out;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr[2] == REG_LOG2_SIDE);
    assign prdata   = (paddr[2] == REG_LOG2_SIDE) ? {29'd0, r_log2_side} : 32'd0;

    // Clamp the image side to the path depth
    assign w_levels = (32'(r_log2_side) > MAX_LEVELS) ? 3'(MAX_LEVELS) : r_log2_side;

    assign o_ready  = w_free;
    assign w_accept = i_valid && w_free;

    qpd_step #(
        .MAX_LEVELS (MAX_LEVELS),
        .DW         (DW)
    ) u_step (
        .i_symbol   (i_symbol),
        .i_levels   (w_levels),
        .i_path     (r_path),
        .i_depth    (r_depth),
        .i_black    (r_black),
        .i_complete (r_complete),
        .o_path     (n_path),
        .o_depth    (n_depth),
        .o_black    (n_black),
        .o_complete (n_complete),
        .o_res      (w_res)
    );

    // Advance the decode state per accepted symbol; restart on a register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_log2_side <= LOG2_SIDE_RST;
            r_path      <= '0;
            r_depth     <= '0;
            r_black     <= '0;
            r_complete  <= 1'b0;
        end else if (w_cfg_wr) begin
            r_log2_side <= pwdata[2:0];
            r_path      <= '0;
            r_depth     <= '0;
            r_black     <= '0;
            r_complete  <= 1'b0;
        end else if (w_accept) begin
            r_path      <= n_path;
            r_depth     <= n_depth;
            r_black     <= n_black;
            r_complete  <= n_complete;
        end
    end

    qpd_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_accept),
        .i_res   (w_res),
        .i_ready (i_ready),
        .o_free  (w_free),
        .o_valid (o_valid),
        .o_res   (w_out)
    );

    assign o_fill_row     = w_out.fill_row;
    assign o_fill_col     = w_out.fill_col;
    assign o_fill_side    = w_out.fill_side;
    assign o_fill_colour  = w_out.fill_colour;
    assign o_black_pixels = w_out.black_pixels;
    assign o_image_done   = w_out.image_done;
    assign o_symbol_error = w_out.symbol_error;

endmodule
